// ----- hw/rtl/plq_pkg.sv -----
package plq_pkg;

    localparam int INSTANCES     = 4096;
    localparam int VALUE_BYTES   = 8;
    localparam int MAX_ACCEPTORS = 32;

    localparam int IDX_W  = $clog2(INSTANCES);
    localparam int VAL_W  = 8 * VALUE_BYTES;
    localparam int MASK_W = MAX_ACCEPTORS;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_OLD     = 3'd1,
        ST_DUP     = 3'd2,
        ST_COUNTED = 3'd3,
        ST_NEWRND  = 3'd4,
        ST_CHOSEN  = 3'd5,
        ST_RANGE   = 3'd6
    } status_t;

    // one table row per instance
    typedef struct packed {
        logic [15:0]       round;
        logic [MASK_W-1:0] mask;
        logic [5:0]        votes;
        logic              decided;
        logic [VAL_W-1:0]  held;
    } entry_t;

    typedef struct packed {
        logic [15:0] instance_req;
        logic [15:0] round;
        logic [4:0]  acceptor_id;
        logic [63:0] proposal_value;
        logic [31:0] client_addr;
        logic [15:0] client_port;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] out_instance;
        logic [63:0] chosen_value;
        logic [5:0]  vote_count;
        logic [31:0] reply_addr;
        logic [15:0] reply_port;
    } result_t;

    // keep VALUE_BYTES bytes, zero from the first zero byte onward
    function automatic logic [VAL_W-1:0] norm_value(logic [63:0] v);
        logic [VAL_W-1:0] r;
        logic             live;
        r    = '0;
        live = 1'b1;
        for (int i = 0; i < VALUE_BYTES; i++)
        begin
            if (v[8*i +: 8] == 8'd0)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                r[8*i +: 8] = v[8*i +: 8];
            end
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/plq_table.sv -----
module plq_table (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [plq_pkg::IDX_W-1:0] rd_addr,
    output plq_pkg::entry_t           rd_data,
    input  logic                      wr_en,
    input  logic [plq_pkg::IDX_W-1:0] wr_addr,
    input  plq_pkg::entry_t           wr_data
);
    import plq_pkg::*;

    entry_t mem [INSTANCES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/plq_vote.sv -----
module plq_vote (
    input  plq_pkg::item_t   item,
    input  plq_pkg::entry_t  old_entry,
    input  logic [5:0]       acc_count,
    output plq_pkg::entry_t  new_entry,
    output logic             wr_en,
    output plq_pkg::result_t result
);
    import plq_pkg::*;

    logic [5:0]        quorum;
    logic [31:0]       bit_wide;
    logic [MASK_W-1:0] acc_bit;
    logic              in_range;
    logic              acc_ok;
    logic              chosen;
    status_t           status;

    assign quorum   = 6'((7'(acc_count) + 7'd2) >> 1);
    assign bit_wide = 32'd1 << item.acceptor_id;
    assign acc_bit  = bit_wide[MASK_W-1:0];
    assign in_range = 32'(item.instance_req) < INSTANCES;
    assign acc_ok   = 32'(item.acceptor_id) < MAX_ACCEPTORS;

    always_comb
    begin
        new_entry = old_entry;
        wr_en     = 1'b0;
        chosen    = 1'b0;
        priority if (!in_range)
        begin
            status = ST_RANGE;
        end
        else if (old_entry.decided)
        begin
            status = ST_DONE;
        end
        else if (item.round < old_entry.round)
        begin
            status = ST_OLD;
        end
        else if (!acc_ok)
        begin
            status = ST_DUP;
        end
        else if (item.round == old_entry.round)
        begin
            if ((old_entry.mask & acc_bit) != '0)
            begin
                status = ST_DUP;
            end
            else
            begin
                new_entry.mask  = old_entry.mask | acc_bit;
                new_entry.votes = old_entry.votes + 6'd1;
                if (old_entry.held[7:0] == 8'd0)
                begin
                    new_entry.held = norm_value(item.proposal_value);
                end
                wr_en  = 1'b1;
                status = ST_COUNTED;
                chosen = new_entry.votes >= quorum;
            end
        end
        else
        begin
            // higher round restarts the tally with the sender alone
            new_entry.round = item.round;
            new_entry.mask  = acc_bit;
            new_entry.votes = 6'd1;
            new_entry.held  = norm_value(item.proposal_value);
            wr_en  = 1'b1;
            status = ST_NEWRND;
            chosen = quorum <= 6'd1;
        end
        if (chosen)
        begin
            new_entry.decided = 1'b1;
            status            = ST_CHOSEN;
        end
    end

    always_comb
    begin
        result.status       = status;
        result.out_instance = item.instance_req;
        result.chosen_value = chosen ? 64'(new_entry.held) : 64'd0;
        result.vote_count   = in_range ? new_entry.votes : 6'd0;
        result.reply_addr   = chosen ? item.client_addr : 32'd0;
        result.reply_port   = chosen ? item.client_port : 16'd0;
    end

endmodule

// ----- hw/rtl/paxos_learner_quorum_unit.sv -----
// Paxos learner with a majority quorum per consensus instance.
// Input channel (in_valid / in_stall) carries one accepted vote per transfer;
// output channel (out_valid / out_stall) returns exactly one status result for
// each vote, in order. cfg_wr_en / cfg_wr_data write the acceptor count
// (quorum = (n + 2) / 2); write it only while no vote is in flight.
// The instance row is read from the table RAM on the transfer edge; in the
// lookup state it is updated and written back, and the result lands in the
// output register. The lookup state holds in_stall high until the result
// has been loaded, so a new vote is not taken before the previous one has
// been written back.
// A result waits in the output register while out_stall is high; the next
// vote may still be taken, but its update holds until the register drains.
// After rst_n the table is swept to zero, one row a cycle, all 4096 rows;
// in_stall stays high until the sweep ends. Configuration writes are taken
// during the sweep. The acceptor count resets to 3.
module paxos_learner_quorum_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] instance_req,
    input  logic [15:0] round,
    input  logic [4:0]  acceptor_id,
    input  logic [63:0] proposal_value,
    input  logic [31:0] client_addr,
    input  logic [15:0] client_port,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] out_instance,
    output logic [63:0] chosen_value,
    output logic [5:0]  vote_count,
    output logic [31:0] reply_addr,
    output logic [15:0] reply_port
);
    import plq_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  clr_idx_reg;
    logic [5:0]        acc_count_reg;
    item_t             item_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    logic              in_xfer;
    logic              load_out;
    entry_t            rd_entry;
    entry_t            upd_entry;
    logic              upd_wr;
    result_t           upd_result;
    logic              tbl_wr_en;
    logic [IDX_W-1:0]  tbl_wr_addr;
    entry_t            tbl_wr_data;

    assign in_stall = state_reg != S_IDLE;
    assign in_xfer  = in_valid && !in_stall;
    assign load_out = (state_reg == S_LOOKUP) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        unique case (state_reg)
            S_CLEAR:
            begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = clr_idx_reg;
                tbl_wr_data = '0;
            end
            S_LOOKUP:
            begin
                tbl_wr_en   = load_out && upd_wr;
                tbl_wr_addr = item_reg.instance_req[IDX_W-1:0];
                tbl_wr_data = upd_entry;
            end
            default:
            begin
                tbl_wr_en   = 1'b0;
                tbl_wr_addr = item_reg.instance_req[IDX_W-1:0];
                tbl_wr_data = upd_entry;
            end
        endcase
    end

    plq_table u_table (
        .clk     (clk),
        .rd_en   (in_xfer),
        .rd_addr (instance_req[IDX_W-1:0]),
        .rd_data (rd_entry),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data)
    );

    plq_vote u_vote (
        .item      (item_reg),
        .old_entry (rd_entry),
        .acc_count (acc_count_reg),
        .new_entry (upd_entry),
        .wr_en     (upd_wr),
        .result    (upd_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            acc_count_reg <= 6'd3;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                acc_count_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == IDX_W'(INSTANCES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= S_LOOKUP;
                    end
                end
                S_LOOKUP:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.instance_req   <= instance_req;
            item_reg.round          <= round;
            item_reg.acceptor_id    <= acceptor_id;
            item_reg.proposal_value <= proposal_value;
            item_reg.client_addr    <= client_addr;
            item_reg.client_port    <= client_port;
        end
        if (load_out)
        begin
            out_reg <= upd_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign out_instance = out_reg.out_instance;
    assign chosen_value = out_reg.chosen_value;
    assign vote_count   = out_reg.vote_count;
    assign reply_addr   = out_reg.reply_addr;
    assign reply_port   = out_reg.reply_port;

    a_xfer_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == S_LOOKUP)
        else $error("vote transfer did not start a lookup");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !tbl_wr_en)
        else $error("table written while idle");

    a_reply_only_chosen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_CHOSEN |->
            chosen_value == 64'd0 && reply_addr == 32'd0 && reply_port == 16'd0)
        else $error("reply fields set on a result that is not chosen");

    a_range_no_votes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_RANGE |-> vote_count == 6'd0)
        else $error("out of range result carries a vote count");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_reg))
        else $error("stalled result changed");

endmodule
